@@ rtl/core/hhe_pkg.sv @@
// ----------------------------------------------------------------------------
// hhe_pkg: shared types and constants of the header end and length scanner
// Character codes, the case-folded marker text and the byte class record
// passed from the classifier through the queue to the state update.
// ----------------------------------------------------------------------------
package hhe_pkg;

    localparam int MARKER_LEN  = 16;
    localparam int QUEUE_DEPTH = 2;
    localparam int POS_W       = $clog2(MARKER_LEN);
    localparam int LEN_W       = 32;

    localparam logic [7:0] CHAR_CR    = 8'h0d;
    localparam logic [7:0] CHAR_LF    = 8'h0a;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [7:0] CHAR_UPP_A = 8'h41;
    localparam logic [7:0] CHAR_UPP_Z = 8'h5a;
    localparam logic [7:0] CASE_BIT   = 8'h20;

    // Number of CR/LF bytes that close the header.
    localparam logic [2:0] END_SEQ_LEN = 3'd4;

    // "content-length: " in lower case
    localparam logic [7:0] MARKER_TEXT [MARKER_LEN] = '{
        8'h63, 8'h6f, 8'h6e, 8'h74, 8'h65, 8'h6e, 8'h74, 8'h2d,
        8'h6c, 8'h65, 8'h6e, 8'h67, 8'h74, 8'h68, 8'h3a, 8'h20
    };

    typedef struct packed {
        logic                  is_cr;
        logic                  is_lf;
        logic                  is_digit;
        logic [3:0]            digit;
        logic [MARKER_LEN-1:0] marker_hit;
    } byte_class_t;

endpackage

@@ rtl/core/hhe_front.sv @@
// ----------------------------------------------------------------------------
// hhe_front: byte classifier
// Folds letter case and compares one header byte with CR, LF, the decimal
// digits and every marker character in parallel.
// ----------------------------------------------------------------------------
module hhe_front
(
    input  logic [7:0]          data_byte,
    output hhe_pkg::byte_class_t byte_class
);
    import hhe_pkg::*;

    logic [7:0] low_char;
    logic [7:0] digit_off;

    always_comb
    begin
        low_char = data_byte;
        if (data_byte inside {[CHAR_UPP_A:CHAR_UPP_Z]})
        begin
            low_char = data_byte | CASE_BIT;
        end
    end

    assign digit_off = data_byte - CHAR_ZERO;

    always_comb
    begin
        byte_class.is_cr    = (data_byte == CHAR_CR);
        byte_class.is_lf    = (data_byte == CHAR_LF);
        byte_class.is_digit = (data_byte inside {[CHAR_ZERO:CHAR_NINE]});
        byte_class.digit    = digit_off[3:0];
        for (int i = 0; i < MARKER_LEN; i++)
        begin
            byte_class.marker_hit[i] = (low_char == MARKER_TEXT[i]);
        end
    end

endmodule

@@ rtl/core/hhe_queue.sv @@
// ----------------------------------------------------------------------------
// hhe_queue: classified byte queue
// Small register FIFO between the classifier and the state update so that
// each side can stall on its own.
// ----------------------------------------------------------------------------
module hhe_queue
#(
    parameter int DEPTH = hhe_pkg::QUEUE_DEPTH
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  hhe_pkg::byte_class_t push_data,
    input  logic                 pop,
    output hhe_pkg::byte_class_t pop_data,
    output logic                 full,
    output logic                 empty
);
    import hhe_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    byte_class_t      entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg,  count_next;

    assign full     = (count_reg == FULL_CNT);
    assign empty    = (count_reg == '0);
    assign pop_data = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

@@ rtl/core/hhe_back.sv @@
// ----------------------------------------------------------------------------
// hhe_back: scan state update and result register
// Advances the end marker tracking, the marker match and the saturating
// decimal length, and holds each result until it is taken.
// ----------------------------------------------------------------------------
module hhe_back
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       item_valid,
    input  hhe_pkg::byte_class_t       item,
    output logic                       item_pop,
    output logic                       result_valid,
    input  logic                       result_stall,
    output logic                       header_done,
    output logic [hhe_pkg::LEN_W-1:0]  content_length
);
    import hhe_pkg::*;

    localparam int PROD_W = LEN_W + 4;
    localparam logic [POS_W-1:0] LAST_POS = POS_W'(MARKER_LEN - 1);

    logic [2:0]       crlf_reg,    crlf_next;
    logic [POS_W-1:0] pos_reg,     pos_next;
    logic             collect_reg, collect_next;
    logic [LEN_W-1:0] acc_reg,     acc_next;
    logic             valid_reg;
    logic             done_reg;
    logic [LEN_W-1:0] len_reg;
    logic             done_now;
    logic [PROD_W-1:0] prod;

    assign item_pop       = item_valid && (!valid_reg || !result_stall);
    assign result_valid   = valid_reg;
    assign header_done    = done_reg;
    assign content_length = len_reg;

    // value * 10 + digit as (value << 3) + (value << 1) + digit
    assign prod = ({4'b0, acc_reg} << 3) + ({4'b0, acc_reg} << 1)
                + {{(PROD_W-4){1'b0}}, item.digit};

    always_comb
    begin
        crlf_next    = '0;
        pos_next     = pos_reg;
        collect_next = collect_reg;
        acc_next     = acc_reg;

        if (!crlf_reg[0])
        begin
            crlf_next = item.is_cr ? crlf_reg + 1'b1 : '0;
        end
        else
        begin
            crlf_next = item.is_lf ? crlf_reg + 1'b1 : '0;
        end

        if (collect_reg)
        begin
            if (item.is_digit)
            begin
                acc_next = (prod[PROD_W-1:LEN_W] != '0) ? '1 : prod[LEN_W-1:0];
            end
            else
            begin
                collect_next = 1'b0;
            end
        end

        if (item.marker_hit[pos_reg])
        begin
            if (pos_reg == LAST_POS)
            begin
                collect_next = 1'b1;
                pos_next     = '0;
            end
            else
            begin
                pos_next = pos_reg + 1'b1;
            end
        end
        else
        begin
            pos_next = item.marker_hit[0] ? POS_W'(1) : '0;
        end

        done_now = (crlf_next == END_SEQ_LEN);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crlf_reg    <= '0;
            pos_reg     <= '0;
            collect_reg <= 1'b0;
            acc_reg     <= '0;
            valid_reg   <= 1'b0;
        end
        else
        begin
            if (item_pop)
            begin
                valid_reg <= 1'b1;
                if (done_now)
                begin
                    crlf_reg    <= '0;
                    pos_reg     <= '0;
                    collect_reg <= 1'b0;
                    acc_reg     <= '0;
                end
                else
                begin
                    crlf_reg    <= crlf_next;
                    pos_reg     <= pos_next;
                    collect_reg <= collect_next;
                    acc_reg     <= acc_next;
                end
            end
            else if (!result_stall)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_pop)
        begin
            done_reg <= done_now;
            len_reg  <= acc_next;
        end
    end

endmodule

@@ rtl/core/http_header_end_and_length_scan.sv @@
// Path: an accepted byte is written into a queue entry, and its result is then registered
// in the result register, where it is held until the receiver takes it.
// Throughput: one byte per cycle, set by the state update, while the receiver does not stall results.
// The classifier runs in the accepting cycle and feeds a two-entry queue.
// Reset: rst_n clears the scan state, the queue and the result valid flag at once.
// No clearing pass: the block accepts bytes in the first cycle after reset.
// ----------------------------------------------------------------------------
// http_header_end_and_length_scan: HTTP header end and Content-Length scanner
// Scans header bytes for CR LF CR LF and a case-insensitive
// "content-length: " marker, accumulating the decimal length after it.
// ----------------------------------------------------------------------------
module http_header_end_and_length_scan
#(
    parameter int QUEUE_DEPTH = hhe_pkg::QUEUE_DEPTH
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    // input transaction: one header byte
    input  logic                       data_valid,
    output logic                       data_stall,
    input  logic [7:0]                 data_byte,
    // output transaction: done flag and current length
    output logic                       result_valid,
    input  logic                       result_stall,
    output logic                       header_done,
    output logic [hhe_pkg::LEN_W-1:0]  content_length
);
    import hhe_pkg::*;

    byte_class_t in_class;
    byte_class_t q_class;
    logic        q_full;
    logic        q_empty;
    logic        q_pop;
    logic        q_push;

    // Classify the byte as it arrives; all compares are independent.
    hhe_front u_front
    (
        .data_byte  (data_byte),
        .byte_class (in_class)
    );

    // Hold classified bytes here; stall the sender only when the queue fills.
    assign q_push     = data_valid && !q_full;
    assign data_stall = q_full;

    hhe_queue #(.DEPTH(QUEUE_DEPTH)) u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (in_class),
        .pop       (q_pop),
        .pop_data  (q_class),
        .full      (q_full),
        .empty     (q_empty)
    );

    // Advance the scan state and register one result per popped byte.
    // The result register refills in the same cycle that it is taken, if a byte waits in the queue.
    hhe_back u_back
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .item_valid     (!q_empty),
        .item           (q_class),
        .item_pop       (q_pop),
        .result_valid   (result_valid),
        .result_stall   (result_stall),
        .header_done    (header_done),
        .content_length (content_length)
    );

endmodule

@@ rtl/core/hhe_checker.sv @@
// ----------------------------------------------------------------------------
// hhe_checker: port-level checks of the header scanner
// Tracks transactions in flight and the header boundaries seen on the
// result channel.
// ----------------------------------------------------------------------------
module hhe_checker
#(
    parameter int QUEUE_DEPTH = hhe_pkg::QUEUE_DEPTH
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       data_valid,
    input  logic                       data_stall,
    input  logic                       result_valid,
    input  logic                       result_stall,
    input  logic                       header_done,
    input  logic [hhe_pkg::LEN_W-1:0]  content_length
);
    import hhe_pkg::*;

    localparam int FLIGHT_W = $clog2(QUEUE_DEPTH + 2);
    localparam logic [FLIGHT_W-1:0] MAX_FLIGHT = FLIGHT_W'(QUEUE_DEPTH + 1);

    logic                in_acc;
    logic                out_acc;
    logic [FLIGHT_W-1:0] flight_reg;
    logic                new_hdr_reg;
    logic [LEN_W-1:0]    last_len_reg;

    assign in_acc  = data_valid && !data_stall;
    assign out_acc = result_valid && !result_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flight_reg   <= '0;
            new_hdr_reg  <= 1'b1;
            last_len_reg <= '0;
        end
        else
        begin
            flight_reg <= flight_reg + FLIGHT_W'(in_acc) - FLIGHT_W'(out_acc);
            if (out_acc)
            begin
                new_hdr_reg  <= header_done;
                last_len_reg <= content_length;
            end
        end
    end

    // hold the result while the receiver stalls
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(content_length)
        && $stable(header_done))
        else $error("result changed while stalled");

    // never show a result without an accepted byte behind it
    a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> flight_reg != '0)
        else $error("result without an accepted byte");

    // queue plus result register bound the bytes in flight
    a_flight_bound: assert property (@(posedge clk) disable iff (!rst_n)
        flight_reg <= MAX_FLIGHT)
        else $error("too many bytes in flight");

    // first result of a new header starts from zero length
    a_new_header_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && new_hdr_reg |-> content_length == '0)
        else $error("length not cleared after header end");

    // within a header the length never drops
    a_len_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !new_hdr_reg |-> content_length >= last_len_reg)
        else $error("length decreased within a header");

endmodule

bind http_header_end_and_length_scan hhe_checker #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_hhe_checker
(
    .clk            (clk),
    .rst_n          (rst_n),
    .data_valid     (data_valid),
    .data_stall     (data_stall),
    .result_valid   (result_valid),
    .result_stall   (result_stall),
    .header_done    (header_done),
    .content_length (content_length)
);

@@ test/tb_http_header_end_and_length_scan.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_http_header_end_and_length_scan: self-checking bench for the header scanner
// Feeds header bytes through the valid/stall input channel, predicts each
// done flag and length with an in-bench scan model, and compares every output
// transaction in order. Random headers mix well-formed Content-Length lines,
// broken markers, stray CR/LF and raw noise, under random gaps and stalls.
// ----------------------------------------------------------------------------
module tb_http_header_end_and_length_scan;
    import hhe_pkg::*;

    localparam int          CLK_HALF      = 10;
    localparam int          RESET_CYCLES  = 5;
    localparam int          MAX_GAP       = 14;
    localparam int          CYCLE_LIMIT   = 400000;
    localparam int          DRAIN_CYCLES  = 4;
    localparam int          RANDOM_TARGET = 1650;
    localparam int          HOLD_CYCLES   = 80;
    localparam int          HOLD_BYTES    = 60;
    localparam logic [63:0] DECIMAL_BASE  = 64'd10;
    localparam logic [31:0] LEN_MAX       = 32'hffff_ffff;

    typedef struct packed {
        logic             done;
        logic [LEN_W-1:0] length;
    } scan_out_t;

    logic             clk;
    logic             rst_n;
    logic             data_valid;
    logic             data_stall;
    logic [7:0]       data_byte;
    logic             result_valid;
    logic             result_stall;
    logic             header_done;
    logic [LEN_W-1:0] content_length;

    // Scan state of the bench model, mirrors the block after reset.
    logic [2:0]       crlf_seen  = '0;
    logic [4:0]       marker_idx = '0;
    logic             in_length  = 1'b0;
    logic [31:0]      length_acc = '0;

    scan_out_t        expected_scans[$];
    logic [7:0]       header_bytes[$];
    int               err_count   = 0;
    int               bytes_sent  = 0;
    int               cycle_count = 0;
    bit               tx_idle     = 1'b1;
    bit               rx_idle     = 1'b1;
    int               rx_hold     = 0;

    http_header_end_and_length_scan uut
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .data_valid     (data_valid),
        .data_stall     (data_stall),
        .data_byte      (data_byte),
        .result_valid   (result_valid),
        .result_stall   (result_stall),
        .header_done    (header_done),
        .content_length (content_length)
    );

    always
    begin
        clk = 1'b1;
        #CLK_HALF;
        clk = 1'b0;
        #CLK_HALF;
    end

    // Advance the scan model by one byte and return the done flag and length
    // that the block must report for it.
    function automatic scan_out_t scan_byte(input logic [7:0] b);
        logic [63:0] prod;
        logic [7:0]  folded;
        scan_out_t   r;
        // CR LF CR LF tracking: CR advances at even progress, LF at odd;
        // anything else (a CR at odd progress too) drops back to zero
        if (!crlf_seen[0])
            crlf_seen = (b == CHAR_CR) ? crlf_seen + 3'd1 : 3'd0;
        else
            crlf_seen = (b == CHAR_LF) ? crlf_seen + 3'd1 : 3'd0;
        // digits after a completed marker, saturating at all ones
        if (in_length)
        begin
            if (b >= CHAR_ZERO && b <= CHAR_NINE)
            begin
                prod = 64'(length_acc) * DECIMAL_BASE + 64'(b - CHAR_ZERO);
                length_acc = (prod > 64'(LEN_MAX)) ? LEN_MAX : prod[31:0];
            end
            else
            begin
                in_length = 1'b0;
            end
        end
        // case-insensitive marker match; on a miss recheck the byte as a
        // possible first marker byte
        folded = (b >= CHAR_UPP_A && b <= CHAR_UPP_Z) ? (b | CASE_BIT) : b;
        if (marker_idx < MARKER_LEN && folded == MARKER_TEXT[marker_idx[3:0]])
        begin
            marker_idx = marker_idx + 5'd1;
            if (marker_idx == 5'(MARKER_LEN))
            begin
                in_length  = 1'b1;
                marker_idx = '0;
            end
        end
        else
        begin
            marker_idx = (folded == MARKER_TEXT[0]) ? 5'd1 : 5'd0;
        end
        r.done   = (crlf_seen >= END_SEQ_LEN);
        r.length = length_acc;
        // a finished header restarts everything for the next one
        if (r.done)
        begin
            crlf_seen  = '0;
            marker_idx = '0;
            in_length  = 1'b0;
            length_acc = '0;
        end
        return r;
    endfunction

    // Flip the case of a lower-case letter at random.
    function automatic logic [7:0] random_case(input logic [7:0] c);
        if (c >= (CHAR_UPP_A | CASE_BIT) && c <= (CHAR_UPP_Z | CASE_BIT) && $urandom_range(0, 1))
            return c ^ CASE_BIT;
        return c;
    endfunction

    // Offer one byte as an input transaction. Hold valid and data until the
    // block takes it, then record the expected output transaction.
    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = tx_idle ? $urandom_range(0, MAX_GAP) : 0;
        @(negedge clk);
        if (gap > 0)
        begin
            data_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        data_valid <= 1'b1;
        data_byte  <= b;
        do
            @(posedge clk);
        while (data_stall);
        expected_scans.push_back(scan_byte(b));
        bytes_sent++;
    endtask

    task automatic send_header_bytes();
        foreach (header_bytes[i])
            send_byte(header_bytes[i]);
    endtask

    // Drop valid and hold off until every expected transaction has come out.
    task automatic wait_drained();
        @(negedge clk);
        data_valid <= 1'b0;
        while (expected_scans.size() != 0)
            @(posedge clk);
    endtask

    // Build one random header: a few lines, each closed by CR LF, then the
    // final CR LF that ends the header.
    task automatic make_header();
        int n_lines;
        int n;
        int pick;
        header_bytes.delete();
        n_lines = $urandom_range(1, 4);
        repeat (n_lines)
        begin
            pick = $urandom_range(0, 9);
            if (pick < 4)
            begin
                // full marker in mixed case, then a length; long digit runs
                // drive the value into saturation
                for (int i = 0; i < MARKER_LEN; i++)
                    header_bytes.push_back(random_case(MARKER_TEXT[i]));
                n = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 12) : $urandom_range(1, 6);
                repeat (n)
                    header_bytes.push_back(CHAR_ZERO + 8'($urandom_range(0, 9)));
                if ($urandom_range(0, 2) == 0)
                    header_bytes.push_back(8'($urandom_range(32, 126)));
            end
            else if (pick < 6)
            begin
                // marker cut short, then some other character
                n = $urandom_range(1, MARKER_LEN - 1);
                for (int i = 0; i < n; i++)
                    header_bytes.push_back(random_case(MARKER_TEXT[i]));
                header_bytes.push_back(8'($urandom_range(32, 126)));
            end
            else if (pick < 8)
            begin
                // ordinary printable header text
                n = $urandom_range(0, 20);
                repeat (n)
                    header_bytes.push_back(8'($urandom_range(32, 126)));
            end
            else if (pick == 8)
            begin
                // raw noise over the whole byte range
                n = $urandom_range(1, 8);
                repeat (n)
                    header_bytes.push_back(8'($urandom_range(0, 255)));
            end
            else
            begin
                // stray CR with a CR, LF or printable character after it
                header_bytes.push_back(CHAR_CR);
                case ($urandom_range(0, 2))
                    0: header_bytes.push_back(CHAR_CR);
                    1: header_bytes.push_back(CHAR_LF);
                    default: header_bytes.push_back(8'($urandom_range(32, 126)));
                endcase
            end
            header_bytes.push_back(CHAR_CR);
            header_bytes.push_back(CHAR_LF);
        end
        header_bytes.push_back(CHAR_CR);
        header_bytes.push_back(CHAR_LF);
    endtask

    // Byte extremes, a CR at odd progress, a doubled first marker letter with
    // mixed case, one digit, then the end of the header.
    task automatic test_directed();
        tx_idle = 1'b1;
        rx_idle = 1'b1;
        header_bytes = '{8'h00, 8'hff, CHAR_CR, CHAR_CR, CHAR_LF, MARKER_TEXT[0]};
        for (int i = 0; i < MARKER_LEN; i++)
            header_bytes.push_back((i == 0 || i == 8) ? (MARKER_TEXT[i] ^ CASE_BIT)
                                                      : MARKER_TEXT[i]);
        header_bytes.push_back(CHAR_ZERO + 8'd7);
        header_bytes.push_back(CHAR_CR);
        header_bytes.push_back(CHAR_LF);
        header_bytes.push_back(CHAR_CR);
        header_bytes.push_back(CHAR_LF);
        send_header_bytes();
        wait_drained();
    endtask

    // Stall the output for a long stretch while bytes keep coming, so the
    // queue fills and the block stalls its input.
    task automatic test_result_hold();
        int stop_at;
        tx_idle = 1'b0;
        rx_idle = 1'b1;
        rx_hold = HOLD_CYCLES;
        stop_at = bytes_sent + HOLD_BYTES;
        while (bytes_sent < stop_at)
        begin
            make_header();
            send_header_bytes();
        end
        wait_drained();
    endtask

    // Random headers with random gaps on both sides, some runs without gaps,
    // and an occasional full drain between headers.
    task automatic test_random_headers();
        while (bytes_sent < RANDOM_TARGET)
        begin
            tx_idle = ($urandom_range(0, 3) != 0);
            rx_idle = ($urandom_range(0, 3) != 0);
            make_header();
            send_header_bytes();
            if ($urandom_range(0, 7) == 0)
                wait_drained();
        end
        wait_drained();
    endtask

    // Full rate on both channels.
    task automatic test_back_to_back();
        tx_idle = 1'b0;
        rx_idle = 1'b0;
        repeat (8)
        begin
            make_header();
            send_header_bytes();
        end
        wait_drained();
    endtask

    initial
    begin
        rst_n      = 1'b0;
        data_valid = 1'b0;
        data_byte  = '0;
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_directed();
        test_result_hold();
        test_random_headers();
        test_back_to_back();

        // let any trailing output settle before the verdict
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (err_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    // Output side: draw a stall length per transaction, or take a pending
    // long hold, then release stall until one transaction is taken.
    initial
    begin : result_sink
        int gap;
        result_stall = 1'b0;
        forever
        begin
            gap = rx_idle ? $urandom_range(0, MAX_GAP) : 0;
            if (rx_hold > 0)
            begin
                gap     = rx_hold;
                rx_hold = 0;
            end
            @(negedge clk);
            if (gap > 0)
            begin
                result_stall <= 1'b1;
                repeat (gap) @(negedge clk);
            end
            result_stall <= 1'b0;
            do
                @(posedge clk);
            while (!(result_valid && !result_stall));
        end
    end

    // Compare each accepted output transaction with the oldest expectation.
    always @(posedge clk)
    begin : check_results
        scan_out_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            if (expected_scans.size() == 0)
            begin
                $error("unexpected transaction: header_done %0b content_length %0d",
                       header_done, content_length);
                err_count++;
            end
            else
            begin
                want = expected_scans.pop_front();
                if (header_done !== want.done)
                begin
                    $error("header_done: expected %0b, actual %0b", want.done, header_done);
                    err_count++;
                end
                if (content_length !== want.length)
                begin
                    $error("content_length: expected %0d, actual %0d",
                           want.length, content_length);
                    err_count++;
                end
            end
        end
    end

    // Hard stop well past the slowest correct run.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

endmodule

@@ filelist.f @@
rtl/core/hhe_pkg.sv
rtl/core/hhe_front.sv
rtl/core/hhe_queue.sv
rtl/core/hhe_back.sv
rtl/core/http_header_end_and_length_scan.sv
rtl/core/hhe_checker.sv
test/tb_http_header_end_and_length_scan.sv
